// ===== hw/rtl/fnd_pkg.sv =====
// ---------------------------------------------------------------------------
// fnd_pkg
// Shared types, widths, ratio table and helpers for the frequency to note
// deviation block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fnd_pkg;

	localparam int NOTE_COUNT_DEF = 128;

	localparam int FREQ_W      = 18;
	localparam int A3_W        = 13;
	localparam int NOTE_W      = 7;
	localparam int NB_W        = 9;
	localparam int PCT_W       = 7;
	localparam int RATIO_W     = 17;
	localparam int PROD_W      = A3_W + RATIO_W;
	localparam int V_W         = 40;
	localparam int SCALE_SHIFT = 21;
	localparam int REM_W       = V_W + 7;
	localparam int Q_W         = 8;
	localparam int IDX_W       = 9;
	localparam int J_W         = 5;
	localparam int S_W         = 4;

	localparam logic [A3_W-1:0]   A3_RESET = 13'd3520;
	localparam logic [FREQ_W-1:0] FREQ_MAX = 18'd262143;
	localparam logic [PCT_W-1:0]  PCT_MAX  = 7'd100;

	// search state for one item
	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [NOTE_W-1:0] note;
		logic              oor;
	} srch_t;

	// result fields carried down the divider
	typedef struct packed {
		logic [NOTE_W-1:0] closest_note;
		logic [FREQ_W-1:0] closest_frequency;
		logic [NB_W-1:0]   neighbour_note;
		logic [FREQ_W-1:0] neighbour_frequency;
		logic              bend_down;
		logic              out_of_range;
	} res_t;

	// restoring divider state
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [V_W-1:0]   den;
		logic [Q_W-1:0]   quo;
	} div_t;

	// 2^(j/24) in unsigned Q16
	function automatic logic [RATIO_W-1:0] ratio(input logic [J_W-1:0] j);
		case (j)
			5'd0:    return 17'd65536;
			5'd1:    return 17'd67456;
			5'd2:    return 17'd69433;
			5'd3:    return 17'd71468;
			5'd4:    return 17'd73562;
			5'd5:    return 17'd75717;
			5'd6:    return 17'd77936;
			5'd7:    return 17'd80220;
			5'd8:    return 17'd82570;
			5'd9:    return 17'd84990;
			5'd10:   return 17'd87480;
			5'd11:   return 17'd90043;
			5'd12:   return 17'd92682;
			5'd13:   return 17'd95398;
			5'd14:   return 17'd98193;
			5'd15:   return 17'd101070;
			5'd16:   return 17'd104032;
			5'd17:   return 17'd107080;
			5'd18:   return 17'd110218;
			5'd19:   return 17'd113448;
			5'd20:   return 17'd116772;
			5'd21:   return 17'd120194;
			5'd22:   return 17'd123715;
			5'd23:   return 17'd127341;
			default: return 17'd0;
		endcase
	endfunction

	// octave of a half-semitone index, h/24 by reciprocal (exact for h < 300)
	function automatic logic [S_W-1:0] oct_of(input logic [IDX_W-1:0] h);
		logic [IDX_W+8:0] p;
		p = (IDX_W+9)'(h) * (IDX_W+9)'(171);
		return p[12 +: S_W];
	endfunction

	// position within the octave, h mod 24
	function automatic logic [J_W-1:0] semi_of(input logic [IDX_W-1:0] h);
		logic [IDX_W-1:0] base;
		base = IDX_W'(oct_of(h)) * IDX_W'(24);
		return J_W'(h - base);
	endfunction

	// scaled value to frequency, rounded half up and saturated
	function automatic logic [FREQ_W-1:0] to_freq(input logic [V_W-1:0] v);
		logic [V_W-1:0]             r;
		logic [V_W-SCALE_SHIFT-1:0] q;
		r = v + (V_W'(1) << (SCALE_SHIFT - 1));
		q = r[V_W-1:SCALE_SHIFT];
		return (q > (V_W-SCALE_SHIFT)'(FREQ_MAX)) ? FREQ_MAX : q[FREQ_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/fnd_if.sv =====
// ---------------------------------------------------------------------------
// fnd_if
// Valid/ready channels for configuration, input and result transactions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fnd_cfg_if;
	logic        valid;
	logic        ready;
	logic [12:0] a3_reference;
	modport source (output valid, output a3_reference, input ready);
	modport sink (input valid, input a3_reference, output ready);
endinterface

interface fnd_in_if;
	logic        valid;
	logic        ready;
	logic [17:0] input_frequency;
	modport source (output valid, output input_frequency, input ready);
	modport sink (input valid, input input_frequency, output ready);
endinterface

interface fnd_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  closest_note;
	logic [17:0] closest_frequency;
	logic [8:0]  neighbour_note;
	logic [17:0] neighbour_frequency;
	logic        bend_down;
	logic [6:0]  bend_percent;
	logic        out_of_range;
	modport source (output valid, output closest_note, output closest_frequency,
		output neighbour_note, output neighbour_frequency, output bend_down,
		output bend_percent, output out_of_range, input ready);
	modport sink (input valid, input closest_note, input closest_frequency,
		input neighbour_note, input neighbour_frequency, input bend_down,
		input bend_percent, input out_of_range, output ready);
endinterface

// ===== hw/rtl/fnd_search_step.sv =====
// ---------------------------------------------------------------------------
// fnd_search_step
// One bit of the binary note search: boundary product, then compare.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnd_search_step
	import fnd_pkg::*;
#(
	parameter int NOTE_COUNT = NOTE_COUNT_DEF,
	parameter int BIT        = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [A3_W-1:0]   a3,
	input  logic              in_valid,
	output logic              in_ready,
	input  srch_t             in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output srch_t             out_data
);

	logic              v_s1, v_s2;
	logic              adv1, adv2;
	srch_t             d_s1, d_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [S_W-1:0]    oct_s1;
	logic [NOTE_W-1:0] try_in, try_s1;
	logic [IDX_W-1:0]  h_in;
	logic [V_W-1:0]    x_s1, vtry_s1;
	logic              take;

	// stage handshake
	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// candidate note and its lower boundary index 2n+5
	assign try_in = in_data.note | NOTE_W'(1 << BIT);
	assign h_in   = IDX_W'({try_in, 1'b1}) + IDX_W'(4);

	// compare input against the candidate boundary
	assign try_s1  = d_s1.note | NOTE_W'(1 << BIT);
	assign x_s1    = V_W'({d_s1.freq, {SCALE_SHIFT{1'b0}}});
	assign vtry_s1 = V_W'(prod_s1) << oct_s1;
	assign take    = !d_s1.oor && (IDX_W'(try_s1) < IDX_W'(NOTE_COUNT))
		&& (x_s1 >= vtry_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			d_s1    <= in_data;
			prod_s1 <= PROD_W'(a3) * PROD_W'(ratio(semi_of(h_in)));
			oct_s1  <= oct_of(h_in);
		end
		if (adv2 && v_s1) begin
			d_s2.freq <= d_s1.freq;
			d_s2.oor  <= d_s1.oor;
			d_s2.note <= take ? try_s1 : d_s1.note;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = d_s2;

endmodule

// ===== hw/rtl/fnd_div_step.sv =====
// ---------------------------------------------------------------------------
// fnd_div_step
// One quotient bit of the restoring divider for the bend percentage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnd_div_step
	import fnd_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_div,
	input  res_t in_res,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_div,
	output res_t out_res
);

	logic             v_s1;
	logic             adv;
	div_t             div_s1;
	res_t             res_s1;
	logic [REM_W-1:0] dsh;
	logic             ge;
	logic [Q_W-1:0]   quo_nx;

	assign adv      = !v_s1 || out_ready;
	assign in_ready = adv;

	// trial subtract of the shifted divisor
	assign dsh    = REM_W'(in_div.den) << SHIFT;
	assign ge     = in_div.rem >= dsh;
	assign quo_nx = in_div.quo | (Q_W'(ge) << SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			res_s1     <= in_res;
			div_s1.den <= in_div.den;
			div_s1.rem <= ge ? in_div.rem - dsh : in_div.rem;
			div_s1.quo <= quo_nx;
		end
	end

	assign out_valid = v_s1;
	assign out_div   = div_s1;
	assign out_res   = res_s1;

endmodule

// ===== hw/rtl/frequency_to_note_deviation.sv =====
// ---------------------------------------------------------------------------
// frequency_to_note_deviation
// Throughput: one transaction per cycle unless note_out.ready stalls the
// pipeline; each search bit and divider bit owns its stages, so no unit is
// shared between items.
// Reset: all pipeline valid bits clear, tuning returns to 220 Hz.
// Nearest note by binary search over boundary products, then neighbour,
// deviation and percentage via a restoring divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module frequency_to_note_deviation
	import fnd_pkg::*;
#(
	parameter int NOTE_COUNT = NOTE_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	fnd_cfg_if.sink   cfg,
	fnd_in_if.sink    freq_in,
	fnd_out_if.source note_out
);

	localparam int NB   = $clog2(NOTE_COUNT);
	localparam int HI_H = 2 * NOTE_COUNT + 5;
	localparam logic [J_W-1:0] HI_J = J_W'(HI_H % 24);
	localparam logic [S_W-1:0] HI_S = S_W'(HI_H / 24);
	localparam logic [J_W-1:0] LO_J = J_W'(5);

	logic [A3_W-1:0] a3_q;

	// tuning register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) a3_q <= A3_RESET;
		else if (cfg.valid) a3_q <= cfg.a3_reference;
	end

	// range check: bottom and top boundary products, then compare
	logic              rng_v_s1, rng_v_s2, rng_adv1, rng_adv2;
	logic [FREQ_W-1:0] rng_f_s1;
	logic [PROD_W-1:0] rng_lo_s1, rng_hi_s1;
	logic [V_W-1:0]    rng_x;
	srch_t             rng_d_s2;

	logic  srch_v [NB+1];
	logic  srch_r [NB+1];
	srch_t srch_d [NB+1];

	assign rng_adv2      = !rng_v_s2 || srch_r[0];
	assign rng_adv1      = !rng_v_s1 || rng_adv2;
	assign freq_in.ready = rng_adv1;
	assign rng_x         = V_W'({rng_f_s1, {SCALE_SHIFT{1'b0}}});

	always_ff @(posedge clk) begin
		if (rng_adv1 && freq_in.valid) begin
			rng_f_s1  <= freq_in.input_frequency;
			rng_lo_s1 <= PROD_W'(a3_q) * PROD_W'(ratio(LO_J));
			rng_hi_s1 <= PROD_W'(a3_q) * PROD_W'(ratio(HI_J));
		end
		if (rng_adv2 && rng_v_s1) begin
			rng_d_s2.freq <= rng_f_s1;
			rng_d_s2.note <= '0;
			rng_d_s2.oor  <= (rng_f_s1 == '0) || (a3_q == '0)
				|| (rng_x < V_W'(rng_lo_s1))
				|| (rng_x >= (V_W'(rng_hi_s1) << HI_S));
		end
	end

	assign srch_v[0] = rng_v_s2;
	assign srch_d[0] = rng_d_s2;

	// binary search, most significant note bit first
	for (genvar i = 0; i < NB; i++) begin : g_search
		fnd_search_step #(
			.NOTE_COUNT (NOTE_COUNT),
			.BIT        (NB - 1 - i)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.a3        (a3_q),
			.in_valid  (srch_v[i]),
			.in_ready  (srch_r[i]),
			.in_data   (srch_d[i]),
			.out_valid (srch_v[i+1]),
			.out_ready (srch_r[i+1]),
			.out_data  (srch_d[i+1])
		);
	end

	// tail: products for note and both neighbours, shift, differences, scale
	logic              tl_v_s1, tl_v_s2, tl_v_s3, tl_v_s4;
	logic              tl_adv1, tl_adv2, tl_adv3, tl_adv4;
	srch_t             tl_d_s1, tl_d_s2;
	logic [PROD_W-1:0] tl_pc_s1, tl_pu_s1, tl_pd_s1;
	logic [S_W-1:0]    tl_oc_s1, tl_ou_s1, tl_od_s1;
	logic [V_W-1:0]    tl_vc_s2, tl_vu_s2, tl_vd_s2;
	logic [V_W-1:0]    tl_vc_s3, tl_vn_s3, tl_num_s3, tl_den_s3;
	res_t              tl_res_s3, tl_res_s4;
	div_t              tl_div_s4;
	logic [IDX_W-1:0]  hc, hu, hd;
	logic [V_W-1:0]    x3;
	logic              down3;

	logic div_v [Q_W+1];
	logic div_r [Q_W+1];
	div_t div_d [Q_W+1];
	res_t div_res [Q_W+1];

	assign tl_adv4         = !tl_v_s4 || div_r[0];
	assign tl_adv3         = !tl_v_s3 || tl_adv4;
	assign tl_adv2         = !tl_v_s2 || tl_adv3;
	assign tl_adv1         = !tl_v_s1 || tl_adv2;
	assign srch_r[NB]      = tl_adv1;

	assign hc    = IDX_W'({srch_d[NB].note, 1'b0}) + IDX_W'(6);
	assign hu    = IDX_W'({srch_d[NB].note, 1'b0}) + IDX_W'(8);
	assign hd    = IDX_W'({srch_d[NB].note, 1'b0}) + IDX_W'(4);
	assign x3    = V_W'({tl_d_s2.freq, {SCALE_SHIFT{1'b0}}});
	assign down3 = tl_vc_s2 > x3;

	always_ff @(posedge clk) begin
		if (tl_adv1 && srch_v[NB]) begin
			tl_d_s1  <= srch_d[NB];
			tl_pc_s1 <= PROD_W'(a3_q) * PROD_W'(ratio(semi_of(hc)));
			tl_pu_s1 <= PROD_W'(a3_q) * PROD_W'(ratio(semi_of(hu)));
			tl_pd_s1 <= PROD_W'(a3_q) * PROD_W'(ratio(semi_of(hd)));
			tl_oc_s1 <= oct_of(hc);
			tl_ou_s1 <= oct_of(hu);
			tl_od_s1 <= oct_of(hd);
		end
		if (tl_adv2 && tl_v_s1) begin
			tl_d_s2  <= tl_d_s1;
			tl_vc_s2 <= V_W'(tl_pc_s1) << tl_oc_s1;
			tl_vu_s2 <= V_W'(tl_pu_s1) << tl_ou_s1;
			tl_vd_s2 <= V_W'(tl_pd_s1) << tl_od_s1;
		end
		if (tl_adv3 && tl_v_s2) begin
			tl_vc_s3  <= tl_vc_s2;
			tl_vn_s3  <= down3 ? tl_vd_s2 : tl_vu_s2;
			tl_num_s3 <= down3 ? tl_vc_s2 - x3 : x3 - tl_vc_s2;
			tl_den_s3 <= down3 ? tl_vc_s2 - tl_vd_s2 : tl_vu_s2 - tl_vc_s2;
			tl_res_s3.closest_note        <= tl_d_s2.note;
			tl_res_s3.closest_frequency   <= '0;
			tl_res_s3.neighbour_note      <= down3
				? NB_W'(tl_d_s2.note) - NB_W'(1) : NB_W'(tl_d_s2.note) + NB_W'(1);
			tl_res_s3.neighbour_frequency <= '0;
			tl_res_s3.bend_down           <= down3;
			tl_res_s3.out_of_range        <= tl_d_s2.oor;
		end
		if (tl_adv4 && tl_v_s3) begin
			tl_res_s4.closest_note        <= tl_res_s3.closest_note;
			tl_res_s4.closest_frequency   <= to_freq(tl_vc_s3);
			tl_res_s4.neighbour_note      <= tl_res_s3.neighbour_note;
			tl_res_s4.neighbour_frequency <= to_freq(tl_vn_s3);
			tl_res_s4.bend_down           <= tl_res_s3.bend_down;
			tl_res_s4.out_of_range        <= tl_res_s3.out_of_range;
			tl_div_s4.rem <= (REM_W'(tl_num_s3) << 6) + (REM_W'(tl_num_s3) << 5)
				+ (REM_W'(tl_num_s3) << 2);
			tl_div_s4.den <= tl_den_s3;
			tl_div_s4.quo <= '0;
		end
	end

	assign div_v[0]   = tl_v_s4;
	assign div_d[0]   = tl_div_s4;
	assign div_res[0] = tl_res_s4;

	// percentage divider, one quotient bit per stage
	for (genvar k = 0; k < Q_W; k++) begin : g_div
		fnd_div_step #(
			.SHIFT (Q_W - 1 - k)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_v[k]),
			.in_ready  (div_r[k]),
			.in_div    (div_d[k]),
			.in_res    (div_res[k]),
			.out_valid (div_v[k+1]),
			.out_ready (div_r[k+1]),
			.out_div   (div_d[k+1]),
			.out_res   (div_res[k+1])
		);
	end

	// result register
	logic              out_v_q, out_adv;
	res_t              out_res_q;
	logic [PCT_W-1:0]  out_pct_q;
	logic [PCT_W-1:0]  pct;
	res_t              fin;
	res_t              oor_res;

	assign out_adv         = !out_v_q || note_out.ready;
	assign div_r[Q_W]      = out_adv;
	assign fin             = div_res[Q_W];
	assign oor_res         = '{out_of_range: 1'b1, default: '0};
	assign pct = (div_d[Q_W].den == '0) ? '0
		: (div_d[Q_W].quo > Q_W'(PCT_MAX)) ? PCT_MAX : div_d[Q_W].quo[PCT_W-1:0];

	always_ff @(posedge clk) begin
		if (out_adv && div_v[Q_W]) begin
			if (fin.out_of_range) begin
				out_res_q <= oor_res;
				out_pct_q <= '0;
			end else begin
				out_res_q <= fin;
				out_pct_q <= pct;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_v_s1 <= 1'b0;
			rng_v_s2 <= 1'b0;
			tl_v_s1  <= 1'b0;
			tl_v_s2  <= 1'b0;
			tl_v_s3  <= 1'b0;
			tl_v_s4  <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (rng_adv1) rng_v_s1 <= freq_in.valid;
			if (rng_adv2) rng_v_s2 <= rng_v_s1;
			if (tl_adv1) tl_v_s1 <= srch_v[NB];
			if (tl_adv2) tl_v_s2 <= tl_v_s1;
			if (tl_adv3) tl_v_s3 <= tl_v_s2;
			if (tl_adv4) tl_v_s4 <= tl_v_s3;
			if (out_adv) out_v_q <= div_v[Q_W];
		end
	end

	assign note_out.valid               = out_v_q;
	assign note_out.closest_note        = out_res_q.closest_note;
	assign note_out.closest_frequency   = out_res_q.closest_frequency;
	assign note_out.neighbour_note      = out_res_q.neighbour_note;
	assign note_out.neighbour_frequency = out_res_q.neighbour_frequency;
	assign note_out.bend_down           = out_res_q.bend_down;
	assign note_out.bend_percent        = out_pct_q;
	assign note_out.out_of_range        = out_res_q.out_of_range;

endmodule

// ===== hw/rtl/fnd_checker.sv =====
// ---------------------------------------------------------------------------
// fnd_checker
// Port-level checks on result transactions, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [6:0]  closest_note,
	input logic [17:0] closest_frequency,
	input logic [8:0]  neighbour_note,
	input logic [17:0] neighbour_frequency,
	input logic        bend_down,
	input logic [6:0]  bend_percent,
	input logic        out_of_range
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// out of range results carry nothing else
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> closest_note == '0 && closest_frequency == '0
		&& neighbour_note == '0 && neighbour_frequency == '0 && !bend_down
		&& bend_percent == '0)
		else $error("out of range result has nonzero fields");

	// neighbour sits on the far side given by the direction flag
	a_neighbour: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_of_range |->
		neighbour_note == (bend_down ? {2'b00, closest_note} - 9'd1
		: {2'b00, closest_note} + 9'd1))
		else $error("neighbour note inconsistent with direction");

	// percentage is saturated
	a_pct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bend_percent <= 7'd100)
		else $error("bend percentage above 100");

endmodule

bind frequency_to_note_deviation fnd_checker u_fnd_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.out_valid           (note_out.valid),
	.out_ready           (note_out.ready),
	.closest_note        (note_out.closest_note),
	.closest_frequency   (note_out.closest_frequency),
	.neighbour_note      (note_out.neighbour_note),
	.neighbour_frequency (note_out.neighbour_frequency),
	.bend_down           (note_out.bend_down),
	.bend_percent        (note_out.bend_percent),
	.out_of_range        (note_out.out_of_range)
);
